### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RKST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define RKST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/rkst_pkg.sv
// ----------------------------------------------------------------------------
// rkst_pkg
// Shared types and sizes for the running k-th smallest tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rkst_pkg;

    localparam int CAPACITY = 1024;
    localparam int VALUE_W  = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_GET   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_RANK = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_FETCH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic add_start;
        logic get_start;
        logic shift_step;
        logic get_load;
        logic err_full;
        logic err_rank;
        logic clear;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic full;
        logic rank_ok;
        logic ins_done;
    } dp_stat_t;

endpackage

`default_nettype wire

### design/rkst_ctrl.sv
// ----------------------------------------------------------------------------
// rkst_ctrl
// Sequencer: decodes accepted beats and steps the datapath through inserts.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rkst_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_op,
    input  wire rkst_pkg::dp_stat_t   stat,
    output rkst_pkg::ctrl_cmd_t       cmd
);

    rkst_pkg::state_t state_reg;
    rkst_pkg::state_t state_next;
    logic             accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rkst_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == rkst_pkg::S_IDLE) && stat.out_free;
        accept     = s_valid && s_ready;
        case (state_reg)
            rkst_pkg::S_IDLE: begin
                if (accept) begin
                    case (rkst_pkg::op_t'(s_op))
                        rkst_pkg::OP_ADD: begin
                            if (stat.full) begin
                                cmd.err_full = 1'b1;
                            end else begin
                                cmd.add_start = 1'b1;
                                state_next    = rkst_pkg::S_INSERT;
                            end
                        end
                        rkst_pkg::OP_GET: begin
                            if (stat.rank_ok) begin
                                cmd.get_start = 1'b1;
                                state_next    = rkst_pkg::S_FETCH;
                            end else begin
                                cmd.err_rank = 1'b1;
                            end
                        end
                        rkst_pkg::OP_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        default: begin
                            // unused code: drop the beat
                        end
                    endcase
                end
            end
            rkst_pkg::S_INSERT: begin
                cmd.shift_step = 1'b1;
                if (stat.ins_done) begin
                    state_next = rkst_pkg::S_IDLE;
                end
            end
            rkst_pkg::S_FETCH: begin
                cmd.get_load = 1'b1;
                state_next   = rkst_pkg::S_IDLE;
            end
            default: begin
                state_next = rkst_pkg::S_IDLE;
            end
        endcase
    end

    `RKST_ASSERT_NEXT(a_fetch_one_cycle, aclk, aresetn,
        cmd.get_start, state_reg == rkst_pkg::S_FETCH && !s_ready)

endmodule

`default_nettype wire

### design/rkst_datapath.sv
// ----------------------------------------------------------------------------
// rkst_datapath
// Sorted value memory, count and rank registers, insert shifter, result reg.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rkst_datapath (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic signed [rkst_pkg::VALUE_W-1:0]    s_value,
    input  wire rkst_pkg::ctrl_cmd_t                    cmd,
    output rkst_pkg::dp_stat_t                          stat,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [rkst_pkg::VALUE_W-1:0]         m_ranked_value,
    output logic [1:0]                                  m_status
);

    localparam int ADDR_W  = rkst_pkg::ADDR_W;
    localparam int CNT_W   = rkst_pkg::CNT_W;
    localparam int VALUE_W = rkst_pkg::VALUE_W;

    logic [VALUE_W-1:0]        mem [rkst_pkg::CAPACITY];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic                      rd_valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [ADDR_W-1:0]         hole_reg;
    logic [ADDR_W-1:0]         hole_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          count_dec;
    logic [CNT_W-1:0]          rank_reg;
    logic [CNT_W-1:0]          rank_next;
    logic                      m_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    rkst_pkg::status_t         out_status_reg;

    logic                      ins_done;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [VALUE_W-1:0]        wr_data;

    assign count_dec = count_reg - CNT_W'(1);
    assign ins_done  = !rd_valid_reg || (rd_data_reg < value_reg);

    assign stat.out_free = !m_valid_reg || m_ready;
    assign stat.full     = (count_reg == CNT_W'(rkst_pkg::CAPACITY));
    assign stat.rank_ok  = (rank_reg < count_reg);
    assign stat.ins_done = ins_done;

    // Read port: top entry on insert start, rank entry on get, next lower
    // entry while shifting up.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = hole_reg - ADDR_W'(2);
        if (cmd.add_start) begin
            rd_en   = (count_reg != '0);
            rd_addr = count_dec[ADDR_W-1:0];
        end else if (cmd.get_start) begin
            rd_en   = 1'b1;
            rd_addr = rank_reg[ADDR_W-1:0];
        end else if (cmd.shift_step && !ins_done) begin
            rd_en   = (hole_reg > ADDR_W'(1));
        end
    end

    // Write port: move the entry into the hole, or drop the new value in.
    assign wr_en   = cmd.shift_step;
    assign wr_data = ins_done ? value_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[hole_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        hole_next  = hole_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        if (cmd.add_start) begin
            hole_next = count_reg[ADDR_W-1:0];
        end else if (cmd.shift_step && !ins_done) begin
            hole_next = hole_reg - ADDR_W'(1);
        end
        if (cmd.clear) begin
            count_next = '0;
            rank_next  = '0;
        end else begin
            if (cmd.shift_step && ins_done) begin
                count_next = count_reg + CNT_W'(1);
            end
            if (cmd.get_start) begin
                rank_next = rank_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        hole_reg <= hole_next;
        if (cmd.add_start) begin
            value_reg <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rank_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            rank_reg     <= rank_next;
            rd_valid_reg <= rd_en;
            if (cmd.err_full || cmd.err_rank || cmd.get_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.err_full) begin
            out_value_reg  <= '0;
            out_status_reg <= rkst_pkg::ST_FULL;
        end else if (cmd.err_rank) begin
            out_value_reg  <= '0;
            out_status_reg <= rkst_pkg::ST_RANK;
        end else if (cmd.get_load) begin
            out_value_reg  <= rd_data_reg;
            out_status_reg <= rkst_pkg::ST_OK;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_ranked_value = out_value_reg;
    assign m_status       = out_status_reg;

    `RKST_ASSERT_NOW(a_rank_in_range, aclk, aresetn,
        1'b1, rank_reg <= count_reg && count_reg <= CNT_W'(rkst_pkg::CAPACITY))
    `RKST_ASSERT_NOW(a_bottom_ends_scan, aclk, aresetn,
        cmd.shift_step && hole_reg == '0, !rd_valid_reg)
    `RKST_ASSERT_NOW(a_error_zero_value, aclk, aresetn,
        m_valid_reg && out_status_reg != rkst_pkg::ST_OK, out_value_reg == '0)

endmodule

`default_nettype wire

### design/running_kth_smallest_tracker_core.sv
// ----------------------------------------------------------------------------
// running_kth_smallest_tracker_core
// Keeps signed 64-bit values sorted and hands them out in ascending rank.
// ----------------------------------------------------------------------------
// Input beats (s_valid/s_ready, s_op, s_value): add inserts s_value in order,
//   get returns the next ranked value, clear empties the store and the rank,
//   op code 3 is dropped. Result beats (m_valid/m_ready, m_ranked_value,
//   m_status): one per get and one per add into a full store, with
//   m_ranked_value zero whenever m_status reports an error.
// Timing from the accepting edge: error results and clear complete at that
//   edge; a get reads memory there and loads the result register in the
//   FETCH state; an add then moves up the k stored values not smaller than
//   the new one, one entry per cycle through the one-read, one-write memory,
//   and writes the new value into the hole. One operation is in flight at a
//   time: a beat every cycle for clear, and for errors while results are taken.
// Reset empties the store, zeroes the rank and drops any pending result; the
//   memory needs no clearing pass, as only entries below the count are read.
// A stalled receiver holds the result register and s_ready stays low until
//   the held beat is taken; a new beat may be accepted in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module running_kth_smallest_tracker_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_op,
    input  wire logic signed [rkst_pkg::VALUE_W-1:0] s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [rkst_pkg::VALUE_W-1:0]      m_ranked_value,
    output logic [1:0]                               m_status
);

    rkst_pkg::ctrl_cmd_t cmd;
    rkst_pkg::dp_stat_t  stat;

    // Sequencer: decode beats, step the insert scan
    rkst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Storage, counters and the result register
    rkst_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_value        (s_value),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ranked_value (m_ranked_value),
        .m_status       (m_status)
    );

endmodule

`default_nettype wire
